// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the hash block.
// Each macro takes a label, a clock and a property; SFH_ASSERT also takes an active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked on every rising edge, ignored while reset is low.
`define SFH_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Property checked on every rising edge, including during reset.
`define SFH_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`else

`define SFH_ASSERT(label, clk, rst_n, prop)
`define SFH_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ===== hdl/sfh_pkg.sv =====
package sfh_pkg;

    // Default width of the running folded sum.
    localparam int SFH_SUM_BITS = 64;

    // Fixed field widths.
    localparam int KEY_W   = 8;
    localparam int TABLE_W = 16;

    // Number of buckets after reset.
    localparam logic [TABLE_W-1:0] TABLE_RESET = 16'd10;

    // States of the bit-serial modulo unit.
    typedef enum logic [1:0] {
        MOD_IDLE,
        MOD_RUN,
        MOD_DONE
    } t_mod_state;

    // Hand-off request from the accumulator to the modulo unit.
    typedef struct packed {
        logic                load;
        logic [TABLE_W-1:0]  table_size;
    } t_mod_req;

endpackage

// ===== hdl/string_fold_hash_bucket.sv =====
// String-folding hash to a bucket index.
// Input channel: one key byte per request (i_key_byte, signed) with i_last_byte set
// on the final byte. A request is taken on a rising edge with i_in_valid high and
// o_in_stall low. Output channel: one bucket index per key, taken on a rising edge
// with o_out_valid high and i_out_stall low.
// Configuration: i_cfg_we writes i_cfg_data into the bucket count; write it only
// while the block is idle. A bucket count of zero gives index zero.
// Throughput: bytes that are not the last are taken back to back while o_in_stall
// is low. The last byte sets a pending flag, and the input stalls until the modulo
// unit takes the sum. While the modulo unit works, bytes of the next key are still
// accumulated. The modulo unit loads the sum only while idle, takes one sum bit per
// cycle and then raises o_out_valid; it takes no new sum until its index has been
// taken, so receiver stalls also hold back the next key.
// While the receiver stalls, the index holds and a finished next key waits at the
// hand-off, stalling the input. Synchronous reset clears the sum, the byte position
// and both handshakes, and sets the bucket count to 10.
`include "assert_macros.svh"

module string_fold_hash_bucket #(
    parameter int SUM_BITS = sfh_pkg::SFH_SUM_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [sfh_pkg::TABLE_W-1:0]  i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [sfh_pkg::KEY_W-1:0] i_key_byte,
    input  logic                         i_last_byte,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [sfh_pkg::TABLE_W-1:0]  o_bucket_index
);
    import sfh_pkg::*;

    logic [TABLE_W-1:0]  r_table_size;
    logic [SUM_BITS-1:0] r_sum, n_sum;
    logic [1:0]          r_pos, n_pos;
    logic                r_pending, n_pending;

    logic                w_in_fire;
    logic                w_handoff;
    logic                w_mod_ready;
    logic [SUM_BITS-1:0] w_byte_ext;
    logic [SUM_BITS-1:0] w_weighted;
    logic [SUM_BITS-1:0] w_magnitude;
    t_mod_req            w_req;

    // The input stalls only while a finished sum waits for the modulo unit.
    assign o_in_stall = r_pending;
    assign w_in_fire  = i_in_valid && !r_pending;
    assign w_handoff  = r_pending && w_mod_ready;

    // Sign-extend the byte and weight it by its place in the group of four.
    assign w_byte_ext = {{(SUM_BITS-KEY_W){i_key_byte[KEY_W-1]}}, i_key_byte};
    assign w_weighted = w_byte_ext << {r_pos, 3'b000};

    // Magnitude of the two's complement sum; the most negative value maps to itself.
    assign w_magnitude = r_sum[SUM_BITS-1] ? (~r_sum + 1'b1) : r_sum;

    assign w_req.load       = w_handoff;
    assign w_req.table_size = r_table_size;

    // Accumulator and hand-off control.
    always_comb begin
        n_sum     = r_sum;
        n_pos     = r_pos;
        n_pending = r_pending;
        if (w_handoff) begin
            n_sum     = '0;
            n_pending = 1'b0;
        end else if (w_in_fire) begin
            n_sum = r_sum + w_weighted;
            if (i_last_byte) begin
                n_pos     = '0;
                n_pending = 1'b1;
            end else begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum        <= '0;
            r_pos        <= '0;
            r_pending    <= 1'b0;
            r_table_size <= TABLE_RESET;
        end else begin
            r_sum     <= n_sum;
            r_pos     <= n_pos;
            r_pending <= n_pending;
            if (i_cfg_we) r_table_size <= i_cfg_data;
        end
    end

    // Bit-serial modulo unit with its own output register.
    sfh_mod #(
        .SUM_BITS (SUM_BITS)
    ) u_mod (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (w_req),
        .i_magnitude    (w_magnitude),
        .o_ready        (w_mod_ready),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_bucket_index (o_bucket_index)
    );

    `SFH_ASSERT(a_last_pends, i_clk, i_rst_n, (w_in_fire && i_last_byte) |=> (r_pending && r_pos == '0))
    `SFH_ASSERT(a_handoff_clears, i_clk, i_rst_n, w_handoff |=> (!r_pending && r_sum == '0))
    `SFH_ASSERT(a_pos_steps, i_clk, i_rst_n, (w_in_fire && !i_last_byte) |=> (r_pos == $past(r_pos) + 2'd1))

endmodule

// ===== hdl/sfh_mod.sv =====
`include "assert_macros.svh"

module sfh_mod #(
    parameter int SUM_BITS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sfh_pkg::t_mod_req            i_req,
    input  logic [SUM_BITS-1:0]          i_magnitude,
    output logic                         o_ready,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [sfh_pkg::TABLE_W-1:0]  o_bucket_index
);
    import sfh_pkg::*;

    localparam int CNT_W = $clog2(SUM_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SUM_BITS - 1);

    t_mod_state r_state, n_state;

    logic [SUM_BITS-1:0] r_dvd, n_dvd;
    logic [TABLE_W-1:0]  r_rem, n_rem;
    logic [TABLE_W-1:0]  r_div, n_div;
    logic [CNT_W-1:0]    r_cnt, n_cnt;

    logic [TABLE_W:0]    w_trial;
    logic                w_fits;

    // One restoring division step: bring in the next dividend bit and subtract if it fits.
    assign w_trial = {r_rem, r_dvd[SUM_BITS-1]};
    assign w_fits  = (w_trial >= {1'b0, r_div});

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            MOD_IDLE: begin
                if (i_req.load) n_state = MOD_RUN;
            end
            MOD_RUN: begin
                if (r_cnt == '0) n_state = MOD_DONE;
            end
            MOD_DONE: begin
                if (!i_out_stall) n_state = MOD_IDLE;
            end
            default: n_state = MOD_IDLE;
        endcase
    end

    // Datapath registers for the shift-and-subtract loop.
    always_comb begin
        n_dvd = r_dvd;
        n_rem = r_rem;
        n_div = r_div;
        n_cnt = r_cnt;
        case (r_state)
            MOD_IDLE: begin
                if (i_req.load) begin
                    n_dvd = i_magnitude;
                    n_rem = '0;
                    n_div = i_req.table_size;
                    n_cnt = CNT_LAST;
                end
            end
            MOD_RUN: begin
                n_dvd = r_dvd << 1;
                n_rem = w_fits ? TABLE_W'(w_trial - {1'b0, r_div}) : w_trial[TABLE_W-1:0];
                n_cnt = r_cnt - 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Outputs. The remainder register doubles as the output register.
    always_comb begin
        o_ready        = (r_state == MOD_IDLE);
        o_out_valid    = (r_state == MOD_DONE);
        o_bucket_index = (r_div == '0) ? '0 : r_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MOD_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_div <= n_div;
        r_cnt <= n_cnt;
    end

    `SFH_ASSERT(a_run_ends, i_clk, i_rst_n, (r_state == MOD_RUN && r_cnt == '0) |=> (r_state == MOD_DONE))
    `SFH_ASSERT(a_load_runs, i_clk, i_rst_n, (r_state == MOD_IDLE && i_req.load) |=> (r_state == MOD_RUN))
    `SFH_ASSERT(a_rem_range, i_clk, i_rst_n, (o_out_valid && r_div != '0) |-> (r_rem < r_div))

endmodule
